>>> hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and helpers for the double-ended queue block.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int VAL_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_REM_FRONT = 3'd2,
    FN_REM_BACK  = 3'd3,
    FN_LIST_FWD  = 3'd4,
    FN_LIST_BWD  = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic cap;        // capture the accepted input word
    logic do_op;      // perform a single-result command and load its result
    logic list_init;  // clear the listing position
    logic list_emit;  // read one stored value into the output register
  } dq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              list_last;
    logic              out_free;
  } dq_stat_t;

  // Ring position of base + offset, with base < DEPTH and offset <= DEPTH.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Command sequencer: accepts a word, runs it, and steps through listings.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dq_stat_t stat,
  output dq_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   is_list;
  logic   is_known;

  assign is_list  = (stat.func == FN_LIST_FWD) || (stat.func == FN_LIST_BWD);
  assign is_known = (stat.func == FN_INS_FRONT) || (stat.func == FN_INS_BACK) ||
                    (stat.func == FN_REM_FRONT) || (stat.func == FN_REM_BACK) ||
                    is_list;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!is_known) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          state_nxt = (is_list && !stat.empty) ? S_LIST : S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free && stat.list_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      S_EXEC: begin
        if (is_known && stat.out_free) begin
          if (is_list && !stat.empty) begin
            cmd.list_init = 1'b1;
          end else begin
            cmd.do_op = 1'b1;
          end
        end
      end
      S_LIST: begin
        cmd.list_emit = stat.out_free;
      end
      default: ;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cmd) <= 1)
    else $error("dq_ctrl: more than one datapath command in a cycle");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.list_init |=> (state_r == S_LIST) && !stat.empty)
    else $error("dq_ctrl: listing entered with an empty queue");

  a_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> (state_r == S_EXEC) && !in_tready)
    else $error("dq_ctrl: accepted word not executed next");

endmodule

>>> hw/rtl/dq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, front index, entry count and the output register.
// ----------------------------------------------------------------------------
module dq_dpath import dq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dq_cmd_t             cmd,
  output dq_stat_t            stat,
  input  logic [FUNC_W-1:0]   func_in,
  input  logic [VAL_W-1:0]    value_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   status_out,
  output logic [VAL_W-1:0]    value_out,
  output logic                last_out
);

  logic [VAL_W-1:0]  ring_mem [DEPTH];

  logic [FUNC_W-1:0] func_r;
  logic [VAL_W-1:0]  value_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r;
  logic [VAL_W-1:0]  value_out_r;
  logic              last_r;

  logic              empty;
  logic              full;
  logic [IDX_W-1:0]  front_dec;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CNT_W-1:0]  list_off;
  logic [IDX_W-1:0]  rd_addr;
  logic              list_last;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign list_last = ((CNT_W'(idx_r) + 1'b1) == count_r);

  // Forward listing walks from the front, backward from the back.
  assign list_off = (func_r == FN_LIST_FWD) ? CNT_W'(idx_r)
                                            : count_r - 1'b1 - CNT_W'(idx_r);
  assign rd_addr  = wrap_idx(front_r, list_off);

  assign stat.func      = func_r;
  assign stat.empty     = empty;
  assign stat.list_last = list_last;
  assign stat.out_free  = !out_valid_r || out_ready;

  // Queue bookkeeping for single-result commands.
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = wrap_idx(front_r, count_r);
    if (cmd.do_op) begin
      unique case (func_r)
        FN_INS_FRONT: begin
          if (!full) begin
            front_nxt = front_dec;
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
            wr_addr   = front_dec;
          end
        end
        FN_INS_BACK: begin
          if (!full) begin
            count_nxt = count_r + 1'b1;
            wr_en     = 1'b1;
          end
        end
        FN_REM_FRONT: begin
          if (!empty) begin
            front_nxt = wrap_idx(front_r, CNT_W'(1));
            count_nxt = count_r - 1'b1;
          end
        end
        FN_REM_BACK: begin
          if (!empty) begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.list_init) begin
      idx_nxt = '0;
    end else if (cmd.list_emit) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.do_op || cmd.list_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r  <= func_in;
      value_r <= value_in;
    end
  end

  // Ring store write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= value_r;
    end
  end

  // Result register; a listing reads the ring store straight into it.
  always_ff @(posedge clk) begin
    if (cmd.list_emit) begin
      status_r    <= ST_OK;
      value_out_r <= ring_mem[rd_addr];
      last_r      <= list_last;
    end else if (cmd.do_op) begin
      value_out_r <= '0;
      last_r      <= 1'b1;
      priority if ((func_r == FN_INS_FRONT) || (func_r == FN_INS_BACK)) begin
        status_r <= full ? ST_FULL : ST_OK;
      end else begin
        status_r <= empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign status_out = status_r;
  assign value_out  = value_out_r;
  assign last_out   = last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("dq_dpath: entry count beyond depth");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_op && full && ((func_r == FN_INS_FRONT) || (func_r == FN_INS_BACK)))
    |=> $stable(count_r) && $stable(front_r) && (status_r == ST_FULL))
    else $error("dq_dpath: insert into a full queue changed state");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.do_op || cmd.list_emit))
    else $error("dq_dpath: result register overwritten while stalled");

endmodule

>>> hw/rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit values kept in a ring store.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries a command and a value. The six commands insert at
// the front or back, remove from the front or back, or list the queue front
// to back or back to front. Codes six and seven are dropped without a result.
// Inserts and removals return one status word (ok, empty or full) with
// tlast set. A listing returns one word per stored value, in order, with
// tlast on the final one; listing an empty queue returns one empty status.
// Sequence: a word is taken in the idle state and executed in the execute
// state, which waits until the output register is free; an insert or removal
// loads its result into the output register as it executes. A listing reads
// the ring store straight into the output register, once per cycle while the
// receiver does not stall.
// Reset clears the front index, the entry count and the output valid flag;
// the ring store itself is not cleared and needs no clearing pass.
// When the receiver stalls, the pending result holds in the output register,
// one further word may still be accepted, and execution waits for the slot.
// ----------------------------------------------------------------------------
module double_ended_queue_top import dq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] func, [34:3] value_in, [39:35] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] status, [33:2] value_out, [39:34] zero
  output logic        out_tlast   // is_last
);

  dq_cmd_t           cmd;
  dq_stat_t          stat;
  logic [STAT_W-1:0] status_w;
  logic [VAL_W-1:0]  value_w;

  // The controller only sequences; all queue state lives in the datapath.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dq_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .func_in    (in_tdata[2:0]),
    .value_in   (in_tdata[34:3]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .status_out (status_w),
    .value_out  (value_w),
    .last_out   (out_tlast)
  );

  assign out_tdata = {6'b0, value_w, status_w};

endmodule
